@@ hdl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed partition allocator
// Field widths, operation and policy codes, register indexes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // default sizing of the partition table
  localparam int NPART_DEF     = 16;
  localparam int SIZE_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int IDX_FIELD_W = 4;
  localparam int AMT_FIELD_W = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int PCOUNT_W    = 5;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 5'd16;

  // item kinds carried on tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_NEXT  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

endpackage : fpa_pkg

`default_nettype wire

@@ hdl/fixed_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_partition_allocator: fixed partition table with fit-policy grants
// Loads partition sizes and grants free partitions by first, best, next or
// worst fit, using a chain of slot cells that a candidate record walks.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  in_       slave      tuser: op | tdata: part_index, amount (from bit 0)
//  out_      master     tuser: granted | tdata: grant_index, grant_size
//  cfg_      write      index 0 fit_policy, index 1 partition_count
//
//  A load passes through the post state to its result in the output register.
//  A request: the candidate record passes one cell per cycle down the
//  NPART-cell chain, then the grant is decided, marked and registered, and
//  the post state presents it. One item is in the chain at a time.
//  A new item is accepted while the previous result still waits on out_tready.
//  Reset (synchronous, rst_n low) clears the table, the marks and the rover.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_allocator #(
  parameter int NPART     = fpa_pkg::NPART_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fpa_pkg::IN_DATA_W-1:0]   in_tdata,   // part_index, amount
  input  wire logic                            in_tuser,   // op
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [fpa_pkg::OUT_DATA_W-1:0]  out_tdata,  // grant_index, grant_size
  output logic                                 out_tuser,  // granted
  input  wire logic                            cfg_wr_en,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import fpa_pkg::*;

  localparam int IDX_W  = $clog2(NPART);
  localparam int CNT_W  = $clog2(NPART + 1);
  localparam int IDXP_W = IDX_W + 1;
  localparam int REC_W  = 2 * (1 + IDX_W + SIZE_BITS);

  typedef struct packed {
    logic                 sel_found;
    logic [IDX_W-1:0]     sel_idx;
    logic [SIZE_BITS-1:0] sel_size;
    logic                 wrap_found;
    logic [IDX_W-1:0]     wrap_idx;
    logic [SIZE_BITS-1:0] wrap_size;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_POST   = 3'b100
  } state_t;

  state_t                st_r, st_nxt;
  policy_t               fit_policy_r;
  logic [PCOUNT_W-1:0]   part_count_r;
  logic [IDX_W-1:0]      rover_r;
  logic [CNT_W-1:0]      cnt_r;

  // latched request
  logic [SIZE_BITS-1:0]  want_r;
  policy_t               pol_r;
  logic [IDX_W-1:0]      start_r;
  logic [CNT_W-1:0]      count_r;

  // result waiting for the output register
  logic                  res_granted_r;
  logic [IDX_W-1:0]      res_idx_r;
  logic [SIZE_BITS-1:0]  res_size_r;

  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [SIZE_BITS-1:0]  out_size_r;

  logic                  in_op;
  logic [IDX_FIELD_W-1:0] in_part_index;
  logic [AMT_FIELD_W-1:0] in_amount;
  logic                  accept;
  logic                  load_ok;
  logic [CNT_W-1:0]      count_eff;
  logic [SIZE_BITS-1:0]  amount_s;
  logic                  search_done;
  rec_t                  final_rec;
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_BITS-1:0]  pick_size;
  logic [IDXP_W-1:0]     pick_inc;
  logic                  wr_size_en;
  logic                  wr_take_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  out_load;

  logic [REC_W-1:0]      rec_w [NPART+1];

  assign in_op         = in_tuser;
  assign in_part_index = in_tdata[IDX_FIELD_W-1:0];
  assign in_amount     = in_tdata[IDX_FIELD_W +: AMT_FIELD_W];
  assign amount_s      = SIZE_BITS'(in_amount);

  assign in_tready = (st_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_ok   = (int'(in_part_index) < NPART);

  assign count_eff = (int'(part_count_r) > NPART) ? CNT_W'(NPART)
                                                  : CNT_W'(part_count_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
      part_count_r <= PCOUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIT_POLICY: fit_policy_r <= policy_t'(cfg_wdata[1:0]);
        REG_PART_COUNT: part_count_r <= PCOUNT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // chain of slot cells; each cycle a fresh empty record enters cell 0
  assign rec_w[0] = '0;

  genvar g;
  generate
    for (g = 0; g < NPART; g++) begin : g_cell
      fpa_cell #(
        .NPART     (NPART),
        .SIZE_BITS (SIZE_BITS),
        .CELL_IDX  (g)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .want       (want_r),
        .policy     (pol_r),
        .start      (start_r),
        .count      (count_r),
        .wr_size_en (wr_size_en),
        .wr_take_en (wr_take_en),
        .wr_idx     (wr_idx),
        .wr_size    (amount_s),
        .rec_in     (rec_w[g]),
        .rec_out    (rec_w[g+1])
      );
    end
  endgenerate

  // the record leaving the last cell covers the whole table once the pass counter reaches NPART
  assign search_done = (st_r == ST_SEARCH) && (cnt_r == CNT_W'(NPART));
  assign final_rec   = rec_t'(rec_w[NPART]);

  always_comb begin
    pick_found = final_rec.sel_found;
    pick_idx   = final_rec.sel_idx;
    pick_size  = final_rec.sel_size;
    // next fit: nothing at or after the rover, so wrap to the lowest fit
    if (pol_r == POL_NEXT && !final_rec.sel_found) begin
      pick_found = final_rec.wrap_found;
      pick_idx   = final_rec.wrap_idx;
      pick_size  = final_rec.wrap_size;
    end
  end

  assign pick_inc   = {1'b0, pick_idx} + IDXP_W'(1);
  assign wr_size_en = accept && (in_op == OP_LOAD) && load_ok;
  assign wr_take_en = search_done && pick_found;
  assign wr_idx     = (st_r == ST_SEARCH) ? pick_idx : IDX_W'(in_part_index);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) st_nxt = (in_op == OP_REQ) ? ST_SEARCH : ST_POST;
      end
      ST_SEARCH: begin
        if (search_done) st_nxt = ST_POST;
      end
      ST_POST: begin
        if (out_load) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (st_r == ST_POST) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (st_r == ST_SEARCH) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (wr_size_en) begin
        rover_r <= '0;
      end else if (wr_take_en && pol_r == POL_NEXT) begin
        rover_r <= (pick_inc < IDXP_W'(count_r)) ? IDX_W'(pick_inc) : '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // latch the request controls and hold the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      want_r  <= amount_s;
      pol_r   <= fit_policy_r;
      count_r <= count_eff;
      start_r <= (CNT_W'(rover_r) < count_eff) ? rover_r : '0;
    end
    if (accept && in_op == OP_LOAD) begin
      res_granted_r <= 1'b0;
      res_idx_r     <= '0;
      res_size_r    <= '0;
    end else if (search_done) begin
      res_granted_r <= pick_found;
      res_idx_r     <= pick_found ? pick_idx : '0;
      res_size_r    <= pick_found ? pick_size : '0;
    end
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_idx_r     <= res_idx_r;
      out_size_r    <= res_size_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_granted_r;
  assign out_tdata  = {(OUT_DATA_W - IDX_FIELD_W - AMT_FIELD_W)'(0),
                       AMT_FIELD_W'(out_size_r), IDX_FIELD_W'(out_idx_r)};

  // a request always enters the search
  a_req_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_REQ) |=> (st_r == ST_SEARCH))
    else $error("request did not start a search");

  // the pass counter stops at the chain length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SEARCH) |-> (int'(cnt_r) <= NPART))
    else $error("search counter overran the chain");

  // a grant is never smaller than the request
  a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_POST && res_granted_r && $past(st_r) == ST_SEARCH)
      |-> (res_size_r >= want_r))
    else $error("granted partition smaller than requested");

  // a grant lies within the partitions in use
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_POST && res_granted_r)
      |-> (CNT_W'(res_idx_r) < count_r))
    else $error("granted partition beyond the count in use");

  // a refusal or load acknowledge carries zeros
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_POST && !res_granted_r)
      |-> (res_idx_r == '0 && res_size_r == '0))
    else $error("refusal carries a non-zero index or size");

endmodule : fixed_partition_allocator

`default_nettype wire

@@ hdl/fpa_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_cell: one partition slot of the allocator chain
// Holds a partition size and taken mark, and folds its own slot into the
// candidate record handed on to the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell #(
  parameter int NPART     = 16,
  parameter int SIZE_BITS = 16,
  parameter int CELL_IDX  = 0,
  localparam int IDX_W    = $clog2(NPART),
  localparam int CNT_W    = $clog2(NPART + 1),
  localparam int REC_W    = 2 * (1 + IDX_W + SIZE_BITS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // search controls, stable for a whole pass
  input  wire logic [SIZE_BITS-1:0]   want,
  input  wire fpa_pkg::policy_t       policy,
  input  wire logic [IDX_W-1:0]       start,
  input  wire logic [CNT_W-1:0]       count,
  // slot update
  input  wire logic                   wr_size_en,
  input  wire logic                   wr_take_en,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire logic [SIZE_BITS-1:0]   wr_size,
  // candidate record from the previous cell, and to the next
  input  wire logic [REC_W-1:0]       rec_in,
  output logic      [REC_W-1:0]       rec_out
);

  import fpa_pkg::*;

  typedef struct packed {
    logic                 sel_found;
    logic [IDX_W-1:0]     sel_idx;
    logic [SIZE_BITS-1:0] sel_size;
    logic                 wrap_found;
    logic [IDX_W-1:0]     wrap_idx;
    logic [SIZE_BITS-1:0] wrap_size;
  } rec_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] size_r;
  logic                 taken_r;
  rec_t                 rec_i;
  rec_t                 rec_nxt;
  rec_t                 rec_r;
  logic                 fit;
  logic                 take_sel;

  assign rec_i = rec_t'(rec_in);
  assign fit   = (MY_CNT < count) && !taken_r && (size_r >= want);

  always_comb begin
    case (policy)
      POL_FIRST: take_sel = fit && !rec_i.sel_found;
      POL_NEXT:  take_sel = fit && !rec_i.sel_found && (MY_IDX >= start);
      POL_BEST:  take_sel = fit && (!rec_i.sel_found || size_r < rec_i.sel_size);
      default:   take_sel = fit && (!rec_i.sel_found || size_r > rec_i.sel_size);
    endcase
  end

  always_comb begin
    rec_nxt = rec_i;
    if (take_sel) begin
      rec_nxt.sel_found = 1'b1;
      rec_nxt.sel_idx   = MY_IDX;
      rec_nxt.sel_size  = size_r;
    end
    // first fit over the whole range, used when next fit wraps round
    if (fit && !rec_i.wrap_found) begin
      rec_nxt.wrap_found = 1'b1;
      rec_nxt.wrap_idx   = MY_IDX;
      rec_nxt.wrap_size  = size_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      taken_r <= 1'b0;
    end else if (wr_size_en && wr_idx == MY_IDX) begin
      size_r  <= wr_size;
      taken_r <= 1'b0;
    end else if (wr_take_en && wr_idx == MY_IDX) begin
      taken_r <= 1'b1;
    end
  end

  assign rec_out = REC_W'(rec_r);

endmodule : fpa_cell

`default_nettype wire
